/* rtl/core/date_add_days_defines.svh */
// ----------------------------------------------------------------------------
// date_add_days_defines.svh
// Assertion macros shared by the date advance RTL.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_DEFINES_SVH
`define DATE_ADD_DAYS_DEFINES_SVH

// Plain property check, sampled on aclk, quiet while reset is held.
`define DAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication check, sampled on aclk, quiet while reset is held.
`define DAD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dad_pkg.sv */
// ----------------------------------------------------------------------------
// dad_pkg
// Types and constants for the Gregorian date advance block.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 16;
    // running day count: largest start day plus largest increment
    localparam int ACC_W   = 17;
    localparam int CENT_W  = 7;

    localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
    localparam logic [YEAR_W-1:0]  MIN_YEAR = 14'd1;
    localparam logic [DAY_W-1:0]   MIN_DAY  = 5'd1;
    localparam logic [DAY_W-1:0]   SAT_DAY  = 5'd31;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

    // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam logic [CENT_W-1:0] CENT_SPAN = 7'd100;
    localparam logic [CENT_W-1:0] REM_LAST  = 7'd99;

    // position within the 400-year cycle, enough for the leap rule
    typedef struct packed {
        logic [CENT_W-1:0] cent;    // year / 100
        logic [CENT_W-1:0] rem100;  // year % 100
        logic [1:0]        yr_low;  // year % 4
    } cal_pos_t;

endpackage

`default_nettype wire

/* rtl/core/date_add_days.sv */
// ----------------------------------------------------------------------------
// date_add_days
// Gregorian date advance: start date plus a day count, saturating at 9999.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------------
//  s_      | in  | start_day 5, start_month 4, start_year 14,  | -
//          |     | add_days 16, pad 1                         |
//  m_      | out | end_day 5, end_month 4, end_year 14, pad 1 | year_overflow
//
//  Month walk: a transaction crosses N month boundaries on its way to the
//  result (N up to about 2155 for 65535 days), one month a cycle on the
//  single compare/subtract unit.
//  ST_DIV and ST_REM split the year into year/100 and year%100 (reciprocal
//  multiply, then remainder) so the leap rule needs no divider afterwards.
//  s_tready is high only in the idle state; a held result stalls the
//  sequencer in its done state until the sink takes it.
//  Reset: synchronous, active low, returns to idle with no result pending.
//
`default_nettype none
`include "date_add_days_defines.svh"

module date_add_days
    import dad_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // start_day, start_month, start_year, add_days
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // end_day, end_month, end_year
    output logic             m_tuser    // year_overflow
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t              state_reg,  state_next;
    logic [ACC_W-1:0]    day_reg,    day_next;
    logic [MONTH_W-1:0]  month_reg,  month_next;
    logic [YEAR_W-1:0]   year_reg,   year_next;
    logic [CENT_W-1:0]   cent_reg,   cent_next;
    logic [CENT_W-1:0]   rem_reg,    rem_next;
    logic                ovf_reg,    ovf_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [23:0]         m_tdata_reg,  m_tdata_next;
    logic                m_tuser_reg,  m_tuser_next;

    // incoming fields
    logic [DAY_W-1:0]    in_day;
    logic [MONTH_W-1:0]  in_month;
    logic [YEAR_W-1:0]   in_year;
    logic [ADD_W-1:0]    in_add;

    cal_pos_t            pos;
    logic [DAY_W-1:0]    len;
    logic                over;
    logic [ACC_W-1:0]    diff;
    logic [PROD_W-1:0]   prod;
    logic [YEAR_W-1:0]   cent_x100;
    logic                out_free;

    assign in_day   = s_tdata[4:0];
    assign in_month = s_tdata[8:5];
    assign in_year  = s_tdata[22:9];
    assign in_add   = s_tdata[38:23];

    // cent, rem100, yr_low from the top down
    assign pos = {cent_reg, rem_reg, year_reg[1:0]};

    dad_month_len u_len (
        .month (month_reg),
        .pos   (pos),
        .len   (len)
    );

    dad_sub_unit u_sub (
        .day_acc (day_reg),
        .len     (len),
        .over    (over),
        .diff    (diff)
    );

    assign prod      = PROD_W'(year_reg) * PROD_W'(RECIP_100);
    assign cent_x100 = YEAR_W'(cent_reg) * YEAR_W'(CENT_SPAN);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        cent_next     = cent_reg;
        rem_next      = rem_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // clamp the odd codes onto the nearest real date part
                    day_next   = ACC_W'((in_day == '0) ? MIN_DAY : in_day) + ACC_W'(in_add);
                    month_next = (in_month == '0) ? MONTH_JAN
                               : (in_month > MONTH_DEC) ? MONTH_DEC : in_month;
                    year_next  = (in_year == '0) ? MIN_YEAR : in_year;
                    ovf_next   = in_year > MAX_YEAR;
                    state_next = (in_year > MAX_YEAR) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                cent_next  = prod[RECIP_SHIFT +: CENT_W];
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = CENT_W'(year_reg - cent_x100);
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (over) begin
                    day_next = diff;
                    if (month_reg == MONTH_DEC) begin
                        if (year_reg == MAX_YEAR) begin
                            ovf_next   = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + 1'b1;
                            if (rem_reg == REM_LAST) begin
                                rem_next  = '0;
                                cent_next = cent_reg + 1'b1;
                            end else begin
                                rem_next  = rem_reg + 1'b1;
                            end
                        end
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ovf_reg;
                    if (ovf_reg) begin
                        m_tdata_next = {1'b0, MAX_YEAR, MONTH_DEC, SAT_DAY};
                    end else begin
                        m_tdata_next = {1'b0, year_reg, month_reg, day_reg[DAY_W-1:0]};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        day_reg     <= day_next;
        month_reg   <= month_next;
        year_reg    <= year_next;
        cent_reg    <= cent_next;
        rem_reg     <= rem_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // year residues must stay in step with the year while months are walked
    `DAD_ASSERT_IMPL(a_pos_track, state_reg == ST_RUN,
        year_reg == cent_x100 + YEAR_W'(rem_reg), "year residues out of step")
    `DAD_ASSERT_IMPL(a_month_range, state_reg == ST_RUN,
        month_reg >= MONTH_JAN && month_reg <= MONTH_DEC, "month out of range")
    `DAD_ASSERT_IMPL(a_sat_value, m_tvalid && m_tuser,
        m_tdata[4:0] == SAT_DAY && m_tdata[8:5] == MONTH_DEC && m_tdata[22:9] == MAX_YEAR,
        "overflow result not saturated")
    `DAD_ASSERT_IMPL(a_out_range, m_tvalid,
        m_tdata[22:9] >= MIN_YEAR && m_tdata[22:9] <= MAX_YEAR && m_tdata[4:0] != '0,
        "result date out of range")

endmodule

`default_nettype wire

/* rtl/core/dad_month_len.sv */
// ----------------------------------------------------------------------------
// dad_month_len
// Length of the current month, leap rule taken from tracked year residues.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_month_len
    import dad_pkg::*;
(
    input  wire logic [MONTH_W-1:0] month,
    input  wire cal_pos_t           pos,
    output logic [DAY_W-1:0]        len
);

    logic leap;

    always_comb begin
        leap = ((pos.yr_low == 2'd0) && (pos.rem100 != '0))
            || ((pos.rem100 == '0) && (pos.cent[1:0] == 2'd0));
        case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_LEAP : LEN_FEB;
            default:   len = LEN_LONG;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/dad_sub_unit.sv */
// ----------------------------------------------------------------------------
// dad_sub_unit
// Shared compare-and-subtract: takes one month's length off the day count.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_sub_unit
    import dad_pkg::*;
(
    input  wire logic [ACC_W-1:0] day_acc,
    input  wire logic [DAY_W-1:0] len,
    output logic                  over,
    output logic [ACC_W-1:0]      diff
);

    logic [ACC_W-1:0] len_ext;

    always_comb begin
        len_ext = ACC_W'(len);
        over    = day_acc > len_ext;
        diff    = day_acc - len_ext;
    end

endmodule

`default_nettype wire

/* tb/date_add_days_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_test
// Self-checking bench for the Gregorian date advance block.
// ----------------------------------------------------------------------------
// Drives start dates and day counts into the input stream and checks every
// result date against an in-bench calendar predictor, field by field and in
// order. Covers calendar edges (month ends, leap and century years, year
// saturation, out-of-range fields), then random dates under four idle mixes,
// and a long sink hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module date_add_days_test;
    import dad_pkg::*;

    // s_tdata layout, lowest bits first: day, month, year, day count, pad
    typedef struct packed {
        logic              pad;
        logic [ADD_W-1:0]   add_days;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
    } date_req_t;

    // m_tdata layout, lowest bits first: day, month, year, pad
    typedef struct packed {
        logic               pad;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } date_bus_t;

    typedef struct {
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
        logic               year_overflow;
    } end_date_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    end_date_t   expected_dates[$];
    int unsigned mismatch_count  = 0;
    int unsigned dates_sent      = 0;
    int unsigned dates_checked   = 0;
    int unsigned saturated_count = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned sink_hold       = 0;

    date_add_days u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return LEN_SHORT;
            MONTH_FEB: return is_leap(year) ? LEN_LEAP : LEN_FEB;
            default:   return LEN_LONG;
        endcase
    endfunction

    function automatic end_date_t advance_date(input date_req_t req);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned len;
        bit          ovf;
        end_date_t   res;
        day   = req.start_day;
        month = req.start_month;
        year  = req.start_year;
        ovf   = 1'b0;
        // out-of-range fields are clamped first
        if (month == 0)         month = MONTH_JAN;
        if (month > MONTH_DEC)  month = MONTH_DEC;
        if (day == 0)           day   = MIN_DAY;
        if (year == 0)          year  = MIN_YEAR;
        if (year > MAX_YEAR) begin
            ovf = 1'b1;
        end else begin
            // a day past the month end rolls over like added days
            day = day + req.add_days;
            len = days_in_month(month, year);
            while (day > len) begin
                day = day - len;
                month++;
                if (month > MONTH_DEC) begin
                    month = MONTH_JAN;
                    year++;
                    if (year > MAX_YEAR) begin
                        ovf = 1'b1;
                        break;
                    end
                end
                len = days_in_month(month, year);
            end
        end
        if (ovf) begin
            res.end_day   = SAT_DAY;
            res.end_month = MONTH_DEC;
            res.end_year  = MAX_YEAR;
        end else begin
            res.end_day   = day[DAY_W-1:0];
            res.end_month = month[MONTH_W-1:0];
            res.end_year  = year[YEAR_W-1:0];
        end
        res.year_overflow = ovf;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then hold the transaction until taken.
    // tvalid stays high after acceptance so back-to-back items need no
    // drop; anything that stops sending lowers it first.
    // ------------------------------------------------------------------
    task automatic send_date(input int unsigned day, input int unsigned month,
                             input int unsigned year, input int unsigned add);
        date_req_t req;
        req.pad         = 1'b0;
        req.start_day   = day[DAY_W-1:0];
        req.start_month = month[MONTH_W-1:0];
        req.start_year  = year[YEAR_W-1:0];
        req.add_days    = add[ADD_W-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        expected_dates.push_back(advance_date(req));
        dates_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sink: random stalls, or a counted hold-off when one is requested
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: one expectation popped per result transaction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        date_bus_t got;
        end_date_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d/%0d with none expected",
                                          got.end_day, got.end_month, got.end_year));
            end else begin
                want = expected_dates.pop_front();
                dates_checked++;
                if (m_tuser) saturated_count++;
                if (got.end_day !== want.end_day)
                    report_mismatch($sformatf("end_day %0d, expected %0d",
                                              got.end_day, want.end_day));
                if (got.end_month !== want.end_month)
                    report_mismatch($sformatf("end_month %0d, expected %0d",
                                              got.end_month, want.end_month));
                if (got.end_year !== want.end_year)
                    report_mismatch($sformatf("end_year %0d, expected %0d",
                                              got.end_year, want.end_year));
                if (m_tuser !== want.year_overflow)
                    report_mismatch($sformatf("year_overflow %0b, expected %0b",
                                              m_tuser, want.year_overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_calendar_edges();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_date(1, 1, 1, 0);
        send_date(31, 12, 9999, 0);          // last representable date
        send_date(31, 12, 9999, 1);          // one day past: saturate
        send_date(31, 12, 9998, 365);        // lands exactly on the last day
        send_date(31, 12, 9998, 366);
        send_date(1, 1, 9900, 65535);        // runs past 9999 mid-advance
        send_date(28, 2, 2023, 1);           // common year
        send_date(28, 2, 2024, 1);           // leap year
        send_date(28, 2, 1900, 1);           // century, not leap
        send_date(28, 2, 2000, 1);           // 400-year, leap
        send_date(30, 4, 2021, 0);           // day equal to month length
        send_date(31, 1, 2021, 0);
        send_date(31, 12, 2021, 1);          // December rolls to January
        send_date(15, 0, 2020, 0);           // month zero
        send_date(10, 15, 2020, 30);         // month above twelve
        send_date(0, 6, 2020, 0);            // day zero
        send_date(31, 4, 2021, 0);           // day beyond month length
        send_date(31, 2, 2024, 0);
        send_date(1, 1, 0, 365);             // year zero
        send_date(5, 5, 16383, 0);           // start year above maximum
        send_date(1, 1, 10000, 5);
        send_date(1, 1, 1, 65535);           // largest day count
        send_date(31, 15, 16383, 65535);     // every field at its top
        send_date(0, 0, 0, 65535);
        wait_for_results();
    endtask

    task automatic test_random_dates(input int unsigned count,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned add;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) begin
            case ($urandom_range(9))
                0:       year = $urandom_range(16383);
                1:       year = $urandom_range(9999, 9800);
                default: year = $urandom_range(9999, 1);
            endcase
            if ($urandom_range(9) == 0) begin
                month = $urandom_range(15);
                day   = $urandom_range(31);
            end else begin
                month = $urandom_range(12, 1);
                day   = $urandom_range(days_in_month(month, year), 1);
            end
            // mostly short advances, a few across many years
            case ($urandom_range(9))
                7, 8:    add = $urandom_range(4000);
                9:       add = $urandom_range(65535);
                default: add = $urandom_range(400);
            endcase
            send_date(day, month, year, add);
        end
        wait_for_results();
    endtask

    task automatic test_stalled_sink();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        // long hold-off: the first date finishes, its result sits, input stalls
        sink_hold = 600;
        send_date(14, 3, 2019, 1000);
        send_date(29, 2, 2020, 366);
        send_date(1, 12, 1999, 31);
        send_date(20, 7, 4000, 200);
        // pause until everything is back, then resume with no gap
        wait_for_results();
        send_date(31, 10, 2100, 120);
        send_date(1, 3, 2400, 59);
        send_date(28, 2, 2400, 1);
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_calendar_edges();
        test_random_dates(62, 0, 0);
        test_random_dates(60, 48, 0);
        test_random_dates(60, 0, 48);
        test_random_dates(60, 12, 12);
        test_stalled_sink();

        sink_stall_pct = 0;
        repeat (20) @(posedge aclk);
        $display("Sent %0d dates, checked %0d results, %0d saturated at the top year.",
                 dates_sent, dates_checked, saturated_count);
        $display("Covered calendar edges, random dates under four idle mixes, sink hold-off.");
        if (mismatch_count == 0) begin
            $display("date_add_days_test: PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("date_add_days_test: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond a full run of maximal day counts
    initial begin
        #30ms;
        $display("Timed out with %0d results outstanding", expected_dates.size());
        $display("date_add_days_test: FAIL");
        $finish;
    end

endmodule
